// ===== rtl/mwg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared types and constants for the majority walker grid step block.
// ----------------------------------------------------------------------------
package mwg_pkg;

  // Grid side. The coordinate fields are 9 bits wide, so the side is a power of
  // two and wrapping of an incoming coordinate is a plain mask.
  localparam int unsigned GRID_SIDE = 512;
  localparam int unsigned COORD_W   = $clog2(GRID_SIDE);
  localparam int unsigned ADDR_W    = 2 * COORD_W;
  localparam int unsigned CNT_W     = 3;   // a neighbour count runs 0..4
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned PICK_W    = 4;

  localparam logic [FRAC_W-1:0] THRESHOLD_RESET = 16'd42598;

  // action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_NORTH = 2'd1,
    DIR_WEST  = 2'd2,
    DIR_SOUTH = 2'd3
  } dir_e;

  typedef logic [3:0][CNT_W-1:0] count_t;

  // one access to the single-port grid memory
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        wdata;
  } ram_req_t;

endpackage

// ===== rtl/mwg_grid_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_grid_ram
// Single-port direction grid, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mwg_grid_ram (
  input  logic              clk_i,
  input  mwg_pkg::ram_req_t req_i,
  output logic [1:0]        rdata_o
);

  localparam int unsigned Depth = 1 << mwg_pkg::ADDR_W;

  logic [1:0] mem_q [Depth];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mwg_vote.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwg_vote
// Picks the next direction from the neighbour counts: one of the tied maxima
// when the majority is followed, else the random direction.
// ----------------------------------------------------------------------------
module mwg_vote (
  input  mwg_pkg::count_t                  counts_i,
  input  logic [mwg_pkg::PICK_W-1:0]       tie_pick_i,
  input  logic                             use_majority_i,
  input  logic [1:0]                       random_direction_i,
  output logic [1:0]                       dir_o
);

  // tie_pick mod 3
  localparam logic [1:0] MOD3 [16] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0
  };

  logic [mwg_pkg::CNT_W-1:0] best;
  logic [3:0]                is_max;
  logic [2:0]                tie_cnt;
  logic [1:0]                sel;
  logic [1:0]                seen;
  logic                      found;

  always_comb begin
    best = counts_i[0];
    for (int d = 1; d < 4; d++) begin
      if (counts_i[d] > best) begin
        best = counts_i[d];
      end
    end
    for (int d = 0; d < 4; d++) begin
      is_max[d] = (counts_i[d] == best);
    end
    tie_cnt = {2'b00, is_max[0]} + {2'b00, is_max[1]}
            + {2'b00, is_max[2]} + {2'b00, is_max[3]};

    unique case (tie_cnt)
      3'd1:    sel = 2'd0;
      3'd2:    sel = {1'b0, tie_pick_i[0]};
      3'd3:    sel = MOD3[tie_pick_i];
      default: sel = tie_pick_i[1:0];
    endcase

    dir_o = random_direction_i;
    seen  = 2'd0;
    found = 1'b0;
    if (use_majority_i) begin
      for (int d = 0; d < 4; d++) begin
        if (is_max[d] && !found) begin
          if (seen == sel) begin
            dir_o = 2'(d);
            found = 1'b1;
          end else begin
            seen = seen + 2'd1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/majority_walker_grid_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// majority_walker_grid_step
// Walker on a toroidal grid of 2-bit direction cells, grid held in one
// single-port synchronous memory; cell write, cell read and majority step.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+---------------------------------
//  s_axis    | in  | tvalid / tready        | tuser: action; tdata: cell fields
//  m_axis    | out | tvalid / tready        | tdata: read_value, walker x, y
//  cfg       | in  | cfg_we_i (no wait)     | cfg_wdata_i: majority_threshold
//
//  A step is bound by the single memory port: four neighbour reads (the first
//  issued on the accepting edge) and one write-back of the walker's cell.
//  One result slot sits on the output; a request is taken while the slot is
//  empty or being drained in the same cycle, so a stalled output holds back
//  at most one request.
//  Reset sets the walker to the grid centre and the threshold to its default.
//  Grid contents are undefined after reset; no clearing pass is made.
// ----------------------------------------------------------------------------
module majority_walker_grid_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,      // majority_threshold
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  input  logic [47:0] s_axis_tdata_i,   // [8:0] cell_x, [17:9] cell_y,
                                        // [19:18] cell_value,
                                        // [35:20] random_fraction,
                                        // [37:36] random_direction,
                                        // [41:38] tie_pick, [47:42] zero
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [1:0] read_value, [10:2] walker_x,
                                        // [19:11] walker_y, [23:20] zero
);

  localparam int unsigned CoordW = mwg_pkg::COORD_W;
  localparam logic [CoordW-1:0] CoordMax  = CoordW'(mwg_pkg::GRID_SIDE - 1);
  localparam logic [CoordW-1:0] CoordHalf = CoordW'(mwg_pkg::GRID_SIDE / 2);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_NBR   = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_RDOUT = 4'b1000
  } state_e;

  function automatic logic [CoordW-1:0] wrap_inc(logic [CoordW-1:0] v);
    return (v == CoordMax) ? '0 : v + CoordW'(1);
  endfunction

  function automatic logic [CoordW-1:0] wrap_dec(logic [CoordW-1:0] v);
    return (v == '0) ? CoordMax : v - CoordW'(1);
  endfunction

  // neighbour order: east, west, north, south (counting ignores order)
  function automatic logic [mwg_pkg::ADDR_W-1:0] nbr_addr(
    logic [1:0] idx, logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    logic [mwg_pkg::ADDR_W-1:0] a;
    unique case (idx)
      2'd0:    a = {y, wrap_inc(x)};
      2'd1:    a = {y, wrap_dec(x)};
      2'd2:    a = {wrap_inc(y), x};
      default: a = {wrap_dec(y), x};
    endcase
    return a;
  endfunction

  // request fields
  logic [1:0]                 in_action;
  logic [CoordW-1:0]          in_cell_x;
  logic [CoordW-1:0]          in_cell_y;
  logic [1:0]                 in_cell_value;
  logic [mwg_pkg::FRAC_W-1:0] in_frac;
  logic [1:0]                 in_rdir;
  logic [mwg_pkg::PICK_W-1:0] in_pick;

  assign in_action     = s_axis_tuser_i;
  assign in_cell_x     = s_axis_tdata_i[CoordW-1:0];
  assign in_cell_y     = s_axis_tdata_i[9 +: CoordW];
  assign in_cell_value = s_axis_tdata_i[19:18];
  assign in_frac       = s_axis_tdata_i[35:20];
  assign in_rdir       = s_axis_tdata_i[37:36];
  assign in_pick       = s_axis_tdata_i[41:38];

  // state
  state_e                     st_q, st_d;
  logic [1:0]                 nbr_q, nbr_d;
  mwg_pkg::count_t            counts_q, counts_d;
  mwg_pkg::count_t            counts_fin;
  logic [CoordW-1:0]          pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [mwg_pkg::FRAC_W-1:0] thresh_q;
  logic                       use_maj_q, use_maj_d;
  logic [1:0]                 rdir_q, rdir_d;
  logic [mwg_pkg::PICK_W-1:0] pick_q, pick_d;
  logic                       out_valid_q, out_valid_d;
  logic [1:0]                 out_val_q, out_val_d;
  logic [CoordW-1:0]          out_x_q, out_x_d, out_y_q, out_y_d;

  mwg_pkg::ram_req_t          ram_req;
  logic [1:0]                 ram_rdata;
  logic [1:0]                 vote_dir;
  logic                       accept;

  assign s_axis_tready_o = (st_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  mwg_grid_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // last neighbour arrives in the evaluation cycle; fold it in directly
  always_comb begin
    counts_fin = counts_q;
    counts_fin[ram_rdata] = counts_q[ram_rdata] + mwg_pkg::CNT_W'(1);
  end

  mwg_vote u_vote (
    .counts_i           (counts_fin),
    .tie_pick_i         (pick_q),
    .use_majority_i     (use_maj_q),
    .random_direction_i (rdir_q),
    .dir_o              (vote_dir)
  );

  always_comb begin
    st_d        = st_q;
    nbr_d       = nbr_q;
    counts_d    = counts_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    use_maj_d   = use_maj_q;
    rdir_d      = rdir_q;
    pick_d      = pick_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_val_d   = out_val_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    ram_req     = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == mwg_pkg::ACT_WRITE) begin
            // write completes on this edge, result goes straight out
            ram_req.en    = 1'b1;
            ram_req.we    = 1'b1;
            ram_req.addr  = {in_cell_y, in_cell_x};
            ram_req.wdata = in_cell_value;
            out_valid_d   = 1'b1;
            out_val_d     = in_cell_value;
            out_x_d       = pos_x_q;
            out_y_d       = pos_y_q;
          end else if (in_action == mwg_pkg::ACT_STEP) begin
            ram_req.en    = 1'b1;
            ram_req.addr  = nbr_addr(2'd0, pos_x_q, pos_y_q);
            counts_d      = '0;
            nbr_d         = 2'd1;
            use_maj_d     = (in_frac < thresh_q);
            rdir_d        = in_rdir;
            pick_d        = in_pick;
            st_d          = ST_NBR;
          end else begin
            // read, and the spare code behaves as a read
            ram_req.en    = 1'b1;
            ram_req.addr  = {in_cell_y, in_cell_x};
            st_d          = ST_RDOUT;
          end
        end
      end
      ST_NBR: begin
        ram_req.en  = 1'b1;
        ram_req.addr = nbr_addr(nbr_q, pos_x_q, pos_y_q);
        counts_d[ram_rdata] = counts_q[ram_rdata] + mwg_pkg::CNT_W'(1);
        nbr_d = nbr_q + 2'd1;
        if (nbr_q == 2'd3) begin
          st_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = {pos_y_q, pos_x_q};
        ram_req.wdata = vote_dir;
        unique case (vote_dir)
          mwg_pkg::DIR_EAST:  pos_x_d = wrap_inc(pos_x_q);
          mwg_pkg::DIR_NORTH: pos_y_d = wrap_inc(pos_y_q);
          mwg_pkg::DIR_WEST:  pos_x_d = wrap_dec(pos_x_q);
          default:            pos_y_d = wrap_dec(pos_y_q);
        endcase
        out_valid_d = 1'b1;
        out_val_d   = vote_dir;
        out_x_d     = pos_x_d;
        out_y_d     = pos_y_d;
        st_d        = ST_IDLE;
      end
      ST_RDOUT: begin
        out_valid_d = 1'b1;
        out_val_d   = ram_rdata;
        out_x_d     = pos_x_q;
        out_y_d     = pos_y_q;
        st_d        = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      nbr_q       <= 2'd0;
      pos_x_q     <= CoordHalf;
      pos_y_q     <= CoordHalf;
      thresh_q    <= mwg_pkg::THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      nbr_q       <= nbr_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    counts_q  <= counts_d;
    use_maj_q <= use_maj_d;
    rdir_q    <= rdir_d;
    pick_q    <= pick_d;
    out_val_q <= out_val_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_y_q, out_x_q, out_val_q};

`ifndef SYNTHESIS
  // a request is never taken while the result slot stays occupied
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!out_valid_q || m_axis_tready_i))
    else $error("request accepted into a full result slot");

  // grid writes only from a write request or the step write-back
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (st_q == ST_IDLE || st_q == ST_EVAL))
    else $error("grid write outside write or write-back");

  // the evaluation cycle always posts a result
  a_eval_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EVAL) |=> out_valid_q)
    else $error("step finished without a result");

  // a step moves the walker along exactly one axis
  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EVAL) |=>
      (($past(pos_x_q) != pos_x_q) != ($past(pos_y_q) != pos_y_q)))
    else $error("walker did not move by one cell");

  // position holds outside the evaluation cycle
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_EVAL) |=> ($stable(pos_x_q) && $stable(pos_y_q)))
    else $error("walker moved outside a step");
`endif

endmodule
